// ===== hw/rtl/irenc_pkg.sv =====
// Shared types, constants and numeral tables for the integer to Roman numeral encoder.
`timescale 1ns / 1ps
package irenc_pkg;

	localparam int VALUE_W         = 12;
	localparam int IN_TDATA_W      = 16;
	localparam int SYM_W           = 8;
	localparam int QUEUE_DEPTH_DEF = 4;

	localparam logic [SYM_W-1:0] ASCII_I = 8'h49;
	localparam logic [SYM_W-1:0] ASCII_V = 8'h56;
	localparam logic [SYM_W-1:0] ASCII_X = 8'h58;
	localparam logic [SYM_W-1:0] ASCII_L = 8'h4C;
	localparam logic [SYM_W-1:0] ASCII_C = 8'h43;
	localparam logic [SYM_W-1:0] ASCII_D = 8'h44;
	localparam logic [SYM_W-1:0] ASCII_M = 8'h4D;

	typedef enum logic [1:0] {
		DEC_THOU = 2'd0,
		DEC_HUND = 2'd1,
		DEC_TENS = 2'd2,
		DEC_UNIT = 2'd3
	} decade_t;

	typedef enum logic [1:0] {
		SEL_ONE  = 2'd0,
		SEL_FIVE = 2'd1,
		SEL_TEN  = 2'd2
	} sel_t;

	typedef struct packed {
		logic [2:0] thou;
		logic [3:0] hund;
		logic [3:0] tens;
		logic [3:0] unit;
	} digits_t;

	localparam int DIGITS_W = $bits(digits_t);

	function automatic logic [3:0] digit_at(input digits_t dg, input decade_t dec);
		logic [3:0] d;
		begin
			case (dec)
				DEC_THOU: d = {1'b0, dg.thou};
				DEC_HUND: d = dg.hund;
				DEC_TENS: d = dg.tens;
				default:  d = dg.unit;
			endcase
			return d;
		end
	endfunction

	function automatic logic [2:0] pat_len(input decade_t dec, input logic [3:0] d);
		logic [2:0] n;
		begin
			if (dec == DEC_THOU) begin
				n = d[2:0];
			end else begin
				case (d)
					4'd1:    n = 3'd1;
					4'd2:    n = 3'd2;
					4'd3:    n = 3'd3;
					4'd4:    n = 3'd2;
					4'd5:    n = 3'd1;
					4'd6:    n = 3'd2;
					4'd7:    n = 3'd3;
					4'd8:    n = 3'd4;
					4'd9:    n = 3'd2;
					default: n = 3'd0;
				endcase
			end
			return n;
		end
	endfunction

	function automatic sel_t pat_sel(input decade_t dec, input logic [3:0] d,
		input logic [2:0] pos);
		sel_t s;
		begin
			s = SEL_ONE;
			if (dec != DEC_THOU) begin
				if (d == 4'd4 && pos == 3'd1) begin
					s = SEL_FIVE;
				end else if (d inside {[4'd5:4'd8]} && pos == 3'd0) begin
					s = SEL_FIVE;
				end else if (d == 4'd9 && pos == 3'd1) begin
					s = SEL_TEN;
				end
			end
			return s;
		end
	endfunction

	function automatic logic [SYM_W-1:0] sym_of(input decade_t dec, input sel_t s);
		logic [SYM_W-1:0] c;
		begin
			case (dec)
				DEC_THOU: c = ASCII_M;
				DEC_HUND: c = (s == SEL_ONE) ? ASCII_C : (s == SEL_FIVE) ? ASCII_D : ASCII_M;
				DEC_TENS: c = (s == SEL_ONE) ? ASCII_X : (s == SEL_FIVE) ? ASCII_L : ASCII_C;
				default:  c = (s == SEL_ONE) ? ASCII_I : (s == SEL_FIVE) ? ASCII_V : ASCII_X;
			endcase
			return c;
		end
	endfunction

endpackage

// ===== hw/rtl/int_to_roman_encoder.sv =====
// Top level of the integer to Roman numeral encoder.
//
// Input channel s_axis: one word per integer, value in tdata[11:0].
// Output channel m_axis: one ASCII numeral character per word (I V X L C D M)
// in writing order, tlast high on the final character of each numeral.
// A value of zero produces no output words. Values 4000..4095 lead with four M.
// The front end works on one integer at a time: accept, three digit steps using
// parallel constant compares per decade, then hand-off into the digit queue.
// The back end pulls a digit word from the queue, then sends one character per
// cycle while the receiver is ready, 1 to 15 per integer; it does not pull the
// next word until the last character of a numeral is emitted, and its pattern
// position counter sets the rate for long numerals.
// The digit queue (QUEUE_DEPTH words) lets the front end keep converting
// while the receiver stalls; when it fills, s_axis_tready drops.
// Reset clears the queue, both sequencers and the output register.
`timescale 1ns / 1ps
module int_to_roman_encoder #(
	parameter int QUEUE_DEPTH = irenc_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [irenc_pkg::IN_TDATA_W-1:0] s_axis_tdata,  // [11:0] value
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [irenc_pkg::SYM_W-1:0]     m_axis_tdata,   // [7:0] symbol
	output logic                            m_axis_tlast    // last
);
	import irenc_pkg::*;

	logic     push_valid;
	logic     push_ready;
	digits_t  push_word;
	logic     pop_valid;
	logic     pop_ready;
	digits_t  pop_word;

	irenc_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.push_valid    (push_valid),
		.push_ready    (push_ready),
		.push_word     (push_word)
	);

	irenc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_word  (push_word),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_word   (pop_word)
	);

	irenc_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.pop_valid     (pop_valid),
		.pop_ready     (pop_ready),
		.pop_word      (pop_word),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule

// ===== hw/rtl/irenc_front.sv =====
// Front end: accepts integers and splits them into decimal digits, one decade per cycle, units with tens.
`timescale 1ns / 1ps
module irenc_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [irenc_pkg::IN_TDATA_W-1:0]    s_axis_tdata,   // [11:0] value
	output logic                                push_valid,
	input  logic                                push_ready,
	output irenc_pkg::digits_t                  push_word
);
	import irenc_pkg::*;

	typedef enum logic [1:0] {F_IDLE, F_CONV, F_PUSH} fstate_t;

	localparam logic [1:0] STEP_THOU = 2'd0;
	localparam logic [1:0] STEP_HUND = 2'd1;
	localparam logic [1:0] STEP_TENS = 2'd2;

	fstate_t              state_q;
	logic [1:0]           step_q;
	logic [VALUE_W-1:0]   rest_q;
	digits_t              dig_q;

	logic [13:0]          weight;
	logic [3:0]           k;
	logic [13:0]          taken;
	logic [VALUE_W-1:0]   rest_nxt;

	always_comb begin
		case (step_q)
			STEP_THOU: weight = 14'd1000;
			STEP_HUND: weight = 14'd100;
			default:   weight = 14'd10;
		endcase
		k = 4'd0;
		for (int j = 1; j <= 9; j++) begin
			if ({2'b00, rest_q} >= 14'(j * weight)) begin
				k = 4'(j);
			end
		end
		taken    = 14'(k * weight);
		rest_nxt = VALUE_W'({2'b00, rest_q} - taken);
	end

	assign s_axis_tready = (state_q == F_IDLE);
	assign push_valid    = (state_q == F_PUSH) && (dig_q != '0);
	assign push_word     = dig_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			step_q  <= STEP_THOU;
			rest_q  <= '0;
			dig_q   <= '0;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (s_axis_tvalid) begin
						rest_q  <= s_axis_tdata[VALUE_W-1:0];
						step_q  <= STEP_THOU;
						state_q <= F_CONV;
					end
				end
				F_CONV: begin
					rest_q <= rest_nxt;
					case (step_q)
						STEP_THOU: begin
							dig_q.thou <= k[2:0];
							step_q     <= STEP_HUND;
						end
						STEP_HUND: begin
							dig_q.hund <= k;
							step_q     <= STEP_TENS;
						end
						default: begin
							dig_q.tens <= k;
							dig_q.unit <= rest_nxt[3:0];
							state_q    <= F_PUSH;
						end
					endcase
				end
				F_PUSH: begin
					if (dig_q == '0 || push_ready) begin
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	a_unit_digit: assert property (@(posedge clk) disable iff (!arst_n)
		push_valid |-> (push_word.unit <= 4'd9 && push_word.tens <= 4'd9
			&& push_word.hund <= 4'd9))
		else $error("digit out of range");
	a_thou_digit: assert property (@(posedge clk) disable iff (!arst_n)
		push_valid |-> push_word.thou <= 3'd4)
		else $error("thousands digit out of range");
	a_push_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(push_valid && !push_ready) |=> (push_valid && $stable(push_word)))
		else $error("queued word changed while waiting");

endmodule

// ===== hw/rtl/irenc_queue.sv =====
// Small register queue that carries digit words from the front end to the back end.
`timescale 1ns / 1ps
module irenc_queue #(
	parameter int DEPTH = irenc_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push_valid,
	output logic                push_ready,
	input  irenc_pkg::digits_t  push_word,
	output logic                pop_valid,
	input  logic                pop_ready,
	output irenc_pkg::digits_t  pop_word
);
	import irenc_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	digits_t             mem_q [DEPTH];
	logic [PTR_W-1:0]    wr_q;
	logic [PTR_W-1:0]    rd_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                do_push;
	logic                do_pop;

	assign push_ready = (cnt_q != CNT_W'(DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_word   = mem_q[rd_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			cnt_q <= cnt_q + CNT_W'(do_push) - CNT_W'(do_pop);
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(DEPTH))
		else $error("queue count overflow");
	a_cnt_track: assert property (@(posedge clk) disable iff (!arst_n)
		(do_push && !do_pop) |=> cnt_q == $past(cnt_q) + 1'b1)
		else $error("queue count lost a push");
	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == '0) |-> (wr_q == rd_q))
		else $error("queue pointers disagree on empty");

endmodule

// ===== hw/rtl/irenc_back.sv =====
// Back end: walks the digits of one word and sends one numeral character per cycle while the receiver is ready.
`timescale 1ns / 1ps
module irenc_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            pop_valid,
	output logic                            pop_ready,
	input  irenc_pkg::digits_t              pop_word,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [irenc_pkg::SYM_W-1:0]     m_axis_tdata,   // [7:0] symbol
	output logic                            m_axis_tlast    // last
);
	import irenc_pkg::*;

	typedef enum logic {B_IDLE, B_EMIT} bstate_t;

	bstate_t             state_q;
	digits_t             dig_q;
	decade_t             dec_q;
	logic [2:0]          pos_q;
	logic                ovalid_q;
	logic [SYM_W-1:0]    osym_q;
	logic                olast_q;

	logic [3:0]          cur_d;
	logic [2:0]          cur_len;
	logic                slot_free;
	logic                emit;
	logic                end_digit;
	logic                nxt_has;
	decade_t             nxt_dec;
	logic                first_has;
	decade_t             first_dec;

	always_comb begin
		cur_d     = digit_at(dig_q, dec_q);
		cur_len   = pat_len(dec_q, cur_d);
		end_digit = (pos_q == cur_len - 3'd1);
		nxt_has   = 1'b0;
		nxt_dec   = DEC_UNIT;
		for (int i = 3; i >= 0; i--) begin
			if (2'(i) > dec_q && digit_at(dig_q, decade_t'(2'(i))) != 4'd0) begin
				nxt_has = 1'b1;
				nxt_dec = decade_t'(2'(i));
			end
		end
		first_has = 1'b0;
		first_dec = DEC_UNIT;
		for (int i = 3; i >= 0; i--) begin
			if (digit_at(pop_word, decade_t'(2'(i))) != 4'd0) begin
				first_has = 1'b1;
				first_dec = decade_t'(2'(i));
			end
		end
	end

	assign slot_free     = !ovalid_q || m_axis_tready;
	assign emit          = (state_q == B_EMIT) && slot_free;
	assign pop_ready     = (state_q == B_IDLE);
	assign m_axis_tvalid = ovalid_q;
	assign m_axis_tdata  = osym_q;
	assign m_axis_tlast  = olast_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= B_IDLE;
			dig_q    <= '0;
			dec_q    <= DEC_THOU;
			pos_q    <= '0;
			ovalid_q <= 1'b0;
			osym_q   <= '0;
			olast_q  <= 1'b0;
		end else begin
			if (m_axis_tready && !emit) begin
				ovalid_q <= 1'b0;
			end
			case (state_q)
				B_IDLE: begin
					if (pop_valid && first_has) begin
						dig_q   <= pop_word;
						dec_q   <= first_dec;
						pos_q   <= '0;
						state_q <= B_EMIT;
					end
				end
				B_EMIT: begin
					if (emit) begin
						ovalid_q <= 1'b1;
						osym_q   <= sym_of(dec_q, pat_sel(dec_q, cur_d, pos_q));
						olast_q  <= end_digit && !nxt_has;
						if (end_digit) begin
							pos_q <= '0;
							if (nxt_has) begin
								dec_q <= nxt_dec;
							end else begin
								state_q <= B_IDLE;
							end
						end else begin
							pos_q <= pos_q + 3'd1;
						end
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	a_len_nz: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_EMIT) |-> cur_len != 3'd0)
		else $error("walking a zero digit");
	a_pos_in: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_EMIT) |-> pos_q < cur_len)
		else $error("pattern position past end");
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && end_digit && !nxt_has) |=> (state_q == B_IDLE && olast_q))
		else $error("run did not close on last character");

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for int_to_roman_encoder: directed table plus random integers.
`timescale 1ns / 1ps
module tb_top;
	import irenc_pkg::*;

	localparam int N_ROWS       = 22;
	localparam int N_RANDOM     = 108;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 40;
	localparam int CYCLE_LIMIT  = 200000;

	typedef struct packed {
		logic [SYM_W-1:0] symbol;
		logic             last;
	} roman_char_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [SYM_W-1:0]      m_axis_tdata;
	logic                  m_axis_tlast;

	roman_char_t expected_chars[$];
	int          send_idle_pct = 13;
	int          recv_idle_pct = 57;
	bit          hold_request = 1'b0;
	int          errors = 0;
	int          cycles = 0;
	int          values_sent = 0;
	int          zeros_sent = 0;
	int          over_range_sent = 0;
	int          chars_checked = 0;

	int_to_roman_encoder i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d characters outstanding", cycles,
				expected_chars.size());
			$display("int_to_roman_encoder verification failed");
			$finish;
		end
	end

	task automatic roman_step(input int idx, output int weight, output logic [SYM_W-1:0] first,
		output logic [SYM_W-1:0] second);
		second = '0;
		case (idx)
			0:       begin weight = 1000; first = ASCII_M; end
			1:       begin weight = 900;  first = ASCII_C; second = ASCII_M; end
			2:       begin weight = 500;  first = ASCII_D; end
			3:       begin weight = 400;  first = ASCII_C; second = ASCII_D; end
			4:       begin weight = 100;  first = ASCII_C; end
			5:       begin weight = 90;   first = ASCII_X; second = ASCII_C; end
			6:       begin weight = 50;   first = ASCII_L; end
			7:       begin weight = 40;   first = ASCII_X; second = ASCII_L; end
			8:       begin weight = 10;   first = ASCII_X; end
			9:       begin weight = 9;    first = ASCII_I; second = ASCII_X; end
			10:      begin weight = 5;    first = ASCII_V; end
			11:      begin weight = 4;    first = ASCII_I; second = ASCII_V; end
			default: begin weight = 1;    first = ASCII_I; end
		endcase
	endtask

	task automatic predict_numeral(input logic [VALUE_W-1:0] value);
		logic [SYM_W-1:0] chars [15];
		logic [SYM_W-1:0] first;
		logic [SYM_W-1:0] second;
		roman_char_t      ch;
		int               rest;
		int               weight;
		int               n;
		rest = value;
		n = 0;
		for (int i = 0; i < 13; i++) begin
			roman_step(i, weight, first, second);
			while (rest >= weight) begin
				if (n < 15) begin
					chars[n] = first;
					n++;
				end
				if (second != '0 && n < 15) begin
					chars[n] = second;
					n++;
				end
				rest -= weight;
			end
		end
		for (int k = 0; k < n; k++) begin
			ch.symbol = chars[k];
			ch.last = (k == n - 1);
			expected_chars = {expected_chars, ch};
		end
	endtask

	task automatic push_text(input string text);
		roman_char_t ch;
		for (int k = 0; k < text.len(); k++) begin
			ch.symbol = text[k];
			ch.last = (k == text.len() - 1);
			expected_chars = {expected_chars, ch};
		end
	endtask

	task automatic table_row(input int r, output logic [VALUE_W-1:0] value, output string text);
		case (r)
			0:       begin value = 12'd0;    text = "";                end
			1:       begin value = 12'd1;    text = "I";               end
			2:       begin value = 12'd4;    text = "IV";              end
			3:       begin value = 12'd5;    text = "V";               end
			4:       begin value = 12'd9;    text = "IX";              end
			5:       begin value = 12'd14;   text = "*";               end
			6:       begin value = 12'd40;   text = "XL";              end
			7:       begin value = 12'd50;   text = "L";               end
			8:       begin value = 12'd90;   text = "XC";              end
			9:       begin value = 12'd100;  text = "C";               end
			10:      begin value = 12'd400;  text = "CD";              end
			11:      begin value = 12'd500;  text = "D";               end
			12:      begin value = 12'd900;  text = "CM";              end
			13:      begin value = 12'd1000; text = "M";               end
			14:      begin value = 12'd3888; text = "MMMDCCCLXXXVIII"; end
			15:      begin value = 12'd3999; text = "MMMCMXCIX";       end
			16:      begin value = 12'd4000; text = "MMMM";            end
			17:      begin value = 12'd4095; text = "MMMMXCV";         end
			18:      begin value = 12'd2730; text = "*";               end
			19:      begin value = 12'd1365; text = "*";               end
			20:      begin value = 12'd2048; text = "*";               end
			default: begin value = 12'd0;    text = "";                end
		endcase
	endtask

	task automatic offer_value(input logic [VALUE_W-1:0] value, input string text);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {{(IN_TDATA_W-VALUE_W){1'b0}}, value};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		if (text == "*")
			predict_numeral(value);
		else
			push_text(text);
		values_sent++;
		if (value == 0)
			zeros_sent++;
		if (value > 3999)
			over_range_sent++;
	endtask

	initial begin
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		roman_char_t want;
		if (m_axis_tvalid && m_axis_tready) begin
			if (expected_chars.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected character %h last %b", m_axis_tdata, m_axis_tlast);
			end else begin
				want = expected_chars.pop_front();
				chars_checked++;
				if (m_axis_tdata !== want.symbol || m_axis_tlast !== want.last) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: expected %c last %b, got %h last %b",
							want.symbol, want.last, m_axis_tdata, m_axis_tlast);
				end
			end
		end
	end

	initial begin
		logic [VALUE_W-1:0] value;
		string              text;
		int                 pick;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int r = 0; r < N_ROWS; r++) begin
			table_row(r, value, text);
			offer_value(value, text);
		end
		for (int n = 0; n < N_RANDOM; n++) begin
			if (n == N_RANDOM / 3) begin
				send_idle_pct = 57;
				recv_idle_pct = 13;
			end else if (n == 2 * N_RANDOM / 3) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
				hold_request = 1'b1;
			end
			pick = $urandom_range(99);
			if (pick < 6)
				value = 12'd0;
			else if (pick < 12)
				value = 12'd4000 + 12'($urandom_range(95));
			else if (pick < 20)
				value = 12'($urandom_range(4095));
			else
				value = 12'($urandom_range(3999, 1));
			offer_value(value, "*");
		end
		s_axis_tvalid <= 1'b0;
		while (expected_chars.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("sent %0d integers (%0d zero, %0d above 3999), checked %0d characters",
			values_sent, zeros_sent, over_range_sent, chars_checked);
		$display("idle patterns: sender light/receiver heavy, reverse, none; one %0d-cycle stall",
			HOLD_CYCLES);
		if (errors == 0) begin
			$display("int_to_roman_encoder verification clean");
		end else begin
			$display("%0d errors", errors);
			$display("int_to_roman_encoder verification failed");
		end
		$finish;
	end

endmodule
